// ===== sv/pcc_pkg.sv =====
package pcc_pkg;

    localparam int DATA_W    = 16;
    localparam int GAIN_D_W  = 8;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int PROD_W    = DIFF_W + DATA_W;
    localparam int DPROD_W   = DIFF_W + GAIN_D_W + 1;
    localparam int SUM_W     = PROD_W + 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX = CFG_IDX_W'(4);

    localparam logic signed [DATA_W-1:0] OUT_MIN_RESET = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] OUT_MAX_RESET = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct packed {
        logic signed [DATA_W-1:0]   gain_p;
        logic signed [DATA_W-1:0]   gain_i;
        logic        [GAIN_D_W-1:0] gain_d;
        logic signed [DATA_W-1:0]   out_min;
        logic signed [DATA_W-1:0]   out_max;
    } cfg_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] err;
        logic signed [DIFF_W-1:0] dmeas;
    } diff_t;

    typedef struct packed {
        logic signed [PROD_W-1:0]  prop;
        logic signed [PROD_W-1:0]  iprod;
        logic signed [DPROD_W-1:0] dprod;
    } prod_t;

    // Lower bound first, then upper: the upper bound wins when they cross.
    function automatic logic signed [DATA_W-1:0] clamp_sum(
        input logic signed [SUM_W-1:0]  v,
        input logic signed [DATA_W-1:0] lo,
        input logic signed [DATA_W-1:0] hi
    );
        logic signed [SUM_W-1:0] r;
        logic signed [SUM_W-1:0] lo_w;
        logic signed [SUM_W-1:0] hi_w;
        lo_w = {{(SUM_W-DATA_W){lo[DATA_W-1]}}, lo};
        hi_w = {{(SUM_W-DATA_W){hi[DATA_W-1]}}, hi};
        r = v;
        if (r < lo_w)
        begin
            r = lo_w;
        end
        if (r > hi_w)
        begin
            r = hi_w;
        end
        return r[DATA_W-1:0];
    endfunction

endpackage

// ===== sv/pcc_front.sv =====
module pcc_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [pcc_pkg::DATA_W-1:0]  target,
    input  logic signed [pcc_pkg::DATA_W-1:0]  measured,
    output logic                               s1_valid,
    input  logic                               s1_ready,
    output pcc_pkg::diff_t                     s1_data
);
    import pcc_pkg::*;

    logic                     s1_valid_reg;
    diff_t                    s1_data_reg;
    diff_t                    s1_data_next;
    logic signed [DATA_W-1:0] last_measured_reg;
    logic                     first_sample_reg;
    logic                     accept;
    logic signed [DIFF_W-1:0] tgt_w;
    logic signed [DIFF_W-1:0] meas_w;
    logic signed [DIFF_W-1:0] last_w;

    assign in_ready = !s1_valid_reg || s1_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        tgt_w  = {target[DATA_W-1], target};
        meas_w = {measured[DATA_W-1], measured};
        last_w = {last_measured_reg[DATA_W-1], last_measured_reg};
        s1_data_next.err = tgt_w - meas_w;
        // first sample after reset: no previous measurement, zero change
        s1_data_next.dmeas = first_sample_reg ? '0 : (meas_w - last_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            last_measured_reg <= '0;
            first_sample_reg  <= 1'b1;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (accept)
            begin
                last_measured_reg <= measured;
                first_sample_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg <= s1_data_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_data  = s1_data_reg;

    a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !first_sample_reg)
        else $error("first-sample flag still set after an accepted beat");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && !s1_ready)
        else $error("input stalled with an empty front stage");

endmodule

// ===== sv/pcc_mul.sv =====
module pcc_mul (
    input  logic           clk,
    input  logic           rst_n,
    input  pcc_pkg::cfg_t  cfg,
    input  logic           s1_valid,
    output logic           s1_ready,
    input  pcc_pkg::diff_t s1_data,
    output logic           s2_valid,
    input  logic           s2_ready,
    output pcc_pkg::prod_t s2_data
);
    import pcc_pkg::*;

    logic  s2_valid_reg;
    prod_t s2_data_reg;
    prod_t s2_data_next;
    logic  take;

    assign s1_ready = !s2_valid_reg || s2_ready;
    assign take     = s1_valid && s1_ready;

    always_comb
    begin
        s2_data_next.prop  = $signed(s1_data.err) * $signed(cfg.gain_p);
        s2_data_next.iprod = $signed(s1_data.err) * $signed(cfg.gain_i);
        s2_data_next.dprod = $signed(s1_data.dmeas) * $signed({1'b0, cfg.gain_d});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s2_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2_data  = s2_data_reg;

endmodule

// ===== sv/pcc_acc.sv =====
module pcc_acc (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pcc_pkg::cfg_t                     cfg,
    input  logic                              s2_valid,
    output logic                              s2_ready,
    input  pcc_pkg::prod_t                    s2_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [pcc_pkg::DATA_W-1:0] drive
);
    import pcc_pkg::*;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] drive_reg;
    logic signed [DATA_W-1:0] drive_next;
    logic signed [DATA_W-1:0] integrator_reg;
    logic signed [DATA_W-1:0] integrator_next;
    logic signed [SUM_W-1:0]  acc_sum;
    logic signed [SUM_W-1:0]  total;
    logic                     take;

    assign s2_ready = !out_valid_reg || out_ready;
    assign take     = s2_valid && s2_ready;

    always_comb
    begin
        acc_sum = {{(SUM_W-DATA_W){integrator_reg[DATA_W-1]}}, integrator_reg}
                + {{(SUM_W-PROD_W){s2_data.iprod[PROD_W-1]}}, s2_data.iprod};
        integrator_next = clamp_sum(acc_sum, cfg.out_min, cfg.out_max);
        total = {{(SUM_W-PROD_W){s2_data.prop[PROD_W-1]}}, s2_data.prop}
              + {{(SUM_W-DATA_W){integrator_next[DATA_W-1]}}, integrator_next}
              - {{(SUM_W-DPROD_W){s2_data.dprod[DPROD_W-1]}}, s2_data.dprod};
        drive_next = clamp_sum(total, cfg.out_min, cfg.out_max);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            integrator_reg <= '0;
        end
        else
        begin
            if (s2_ready)
            begin
                out_valid_reg <= s2_valid;
            end
            if (take)
            begin
                integrator_reg <= integrator_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            drive_reg <= drive_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid_reg)
        else $error("beat taken into the last stage but no result shown");

    a_drive_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        take && (cfg.out_min <= cfg.out_max)
        |=> (drive_reg >= $past(cfg.out_min)) && (drive_reg <= $past(cfg.out_max))
            && (integrator_reg >= $past(cfg.out_min))
            && (integrator_reg <= $past(cfg.out_max)))
        else $error("drive or integrator outside the clamp window");

endmodule

// ===== sv/pid_controller_clamped_core.sv =====
// Clamped PID controller, derivative taken on the measurement.
//
// Input channel (in_valid/in_ready): one beat carries target and measured.
// Output channel (out_valid/out_ready): one beat carries drive, exactly one
// result per input beat, in order.
// Config channel (cfg_valid/cfg_ready): cfg_index selects gain_p, gain_i,
// gain_d, out_min, out_max (0..4); other indexes are dropped. cfg_ready is
// always high. Write only while no beat is in flight.
//
// An accepted input beat passes three registered stages (front difference,
// multiply, integrate/clamp) to out_valid. Throughput: one beat per cycle
// while out_ready is high; the integrator loop closes in the last stage.
// Each stage holds its own beat, so a stalled receiver fills the stages one
// by one and in_ready drops only once all three hold a beat.
//
// Reset: gains 0, out_min -32768, out_max 32767, integrator and last
// measurement 0, first-sample flag set, all stages empty.
module pid_controller_clamped_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pcc_pkg::DATA_W-1:0]     target,
    input  logic signed [pcc_pkg::DATA_W-1:0]     measured,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [pcc_pkg::DATA_W-1:0]     drive,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic        [pcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [pcc_pkg::DATA_W-1:0]     cfg_data
);
    import pcc_pkg::*;

    cfg_t  cfg_reg;
    logic  s1_valid;
    logic  s1_ready;
    diff_t s1_data;
    logic  s2_valid;
    logic  s2_ready;
    prod_t s2_data;

    assign cfg_ready = 1'b1;

    // Register file: a write touches only the addressed register and
    // leaves the controller state alone.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p  <= '0;
            cfg_reg.gain_i  <= '0;
            cfg_reg.gain_d  <= '0;
            cfg_reg.out_min <= OUT_MIN_RESET;
            cfg_reg.out_max <= OUT_MAX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GAIN_P:  cfg_reg.gain_p  <= cfg_data;
                CFG_GAIN_I:  cfg_reg.gain_i  <= cfg_data;
                CFG_GAIN_D:  cfg_reg.gain_d  <= cfg_data[GAIN_D_W-1:0];
                CFG_OUT_MIN: cfg_reg.out_min <= cfg_data;
                CFG_OUT_MAX: cfg_reg.out_max <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Stage 1: error and measurement change.
    pcc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .target   (target),
        .measured (measured),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1_data  (s1_data)
    );

    // Stage 2: the three gain products, side by side.
    pcc_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1_data  (s1_data),
        .s2_valid (s2_valid),
        .s2_ready (s2_ready),
        .s2_data  (s2_data)
    );

    // Stage 3: integrate, clamp, sum, clamp; result register.
    pcc_acc u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .s2_valid  (s2_valid),
        .s2_ready  (s2_ready),
        .s2_data   (s2_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive     (drive)
    );

endmodule

// ===== bench/pid_controller_clamped_core_tb.sv =====
module pid_controller_clamped_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pcc_pkg::*;

    // Run guard: the slowest correct run stays far below this many cycles.
    localparam int CYCLE_LIMIT = 400000;
    // The core is three stages deep; leave a few more cycles after draining.
    localparam int DRAIN_SLACK = 8;
    // Cap on printed mismatch lines; every mismatch is still counted.
    localparam int PRINT_CAP   = 40;

    // Register indexes past the last real one; the core drops writes to them.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = CFG_IDX_W'(7);

    localparam int S16_MIN = -32768;
    localparam int S16_MAX = 32767;

    typedef struct {
        logic signed [DATA_W-1:0] tgt;
        logic signed [DATA_W-1:0] meas;
    } sample_t;

    // DUT ports; every input starts at a known value.
    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_ready;
    logic signed [DATA_W-1:0]    target    = '0;
    logic signed [DATA_W-1:0]    measured  = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic signed [DATA_W-1:0]    drive;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic        [CFG_IDX_W-1:0] cfg_index = '0;
    logic        [DATA_W-1:0]    cfg_data  = '0;

    // Shadow copy of the register file, as last written.
    logic signed [DATA_W-1:0]    kp     = '0;
    logic signed [DATA_W-1:0]    ki     = '0;
    logic        [GAIN_D_W-1:0]  kd     = '0;
    logic signed [DATA_W-1:0]    lo_lim = OUT_MIN_RESET;
    logic signed [DATA_W-1:0]    hi_lim = OUT_MAX_RESET;

    // Shadow controller state: integrator, last measurement, first-sample flag.
    logic signed [DATA_W-1:0]    integ     = '0;
    logic signed [DATA_W-1:0]    prev_meas = '0;
    logic                        fresh     = 1'b1;

    sample_t                     sample_q[$];     // beats waiting to be sent
    logic signed [DATA_W-1:0]    drive_due_q[$];  // drive values owed by the core

    int items_queued   = 0;
    int items_taken    = 0;
    int drives_checked = 0;
    int reg_writes     = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;

    // Random-walk state for the well-behaved closed-loop traffic.
    int track_tgt  = 0;
    int track_meas = 0;

    pid_controller_clamped_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .target    (target),
        .measured  (measured),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive     (drive),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Hold reset at start-up, then release it for good.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP)
        begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
        error_count++;
    endtask

    // Lower bound first, then upper, so the upper bound wins when they cross.
    function automatic longint limit_to_bounds(input longint v);
        longint r;
        r = v;
        if (r < longint'(lo_lim))
        begin
            r = longint'(lo_lim);
        end
        if (r > longint'(hi_lim))
        begin
            r = longint'(hi_lim);
        end
        return r;
    endfunction

    // Advance the shadow controller by one sample and return the drive it owes.
    function automatic logic signed [DATA_W-1:0] advance_controller(
        input logic signed [DATA_W-1:0] tgt,
        input logic signed [DATA_W-1:0] meas
    );
        longint err;
        longint acc;
        longint slope;
        longint total;
        err = longint'(tgt) - longint'(meas);
        acc = limit_to_bounds(longint'(integ) + err * longint'(ki));
        integ = DATA_W'(acc);
        // First sample after reset: no history, so the slope term is zero.
        if (fresh)
        begin
            fresh = 1'b0;
            prev_meas = meas;
        end
        slope = (longint'(meas) - longint'(prev_meas)) * longint'(kd);
        prev_meas = meas;
        total = limit_to_bounds(err * longint'(kp) + acc - slope);
        return DATA_W'(total);
    endfunction

    // Driver: present queued beats, idling at random, and predict each
    // beat the moment the core takes it.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                drive_due_q.push_back(advance_controller(target, measured));
                items_taken++;
            end
            // Only load a new beat once the current one is gone; valid
            // never drops while a beat waits for acceptance.
            if (!in_valid || in_ready)
            begin
                if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    sample_t nxt;
                    nxt = sample_q.pop_front();
                    in_valid <= 1'b1;
                    target   <= nxt.tgt;
                    measured <= nxt.meas;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check every drive beat against the oldest owed value and
    // throttle the output side at random.
    always @(posedge clk)
    begin
        logic signed [DATA_W-1:0] owed;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (drive_due_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected drive beat %0d", drive));
                end
                else
                begin
                    owed = drive_due_q.pop_front();
                    if (drive !== owed)
                    begin
                        report_mismatch($sformatf("drive %0d, predicted %0d (beat %0d)",
                                                  drive, owed, drives_checked));
                    end
                    drives_checked++;
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles: %0d beats taken, %0d drives still owed",
                     cycle_count, items_taken, drive_due_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Write one register and mirror it in the shadow copy once the beat lands.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            CFG_GAIN_P:  kp = value;
            CFG_GAIN_I:  ki = value;
            CFG_GAIN_D:  kd = value[GAIN_D_W-1:0];
            CFG_OUT_MIN: lo_lim = value;
            CFG_OUT_MAX: hi_lim = value;
            default:     ;
        endcase
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic queue_sample(input int tgt, input int meas);
        sample_t s;
        s.tgt  = DATA_W'(tgt);
        s.meas = DATA_W'(meas);
        sample_q.push_back(s);
        items_queued++;
    endtask

    // Wait until every queued beat is taken and every drive has come back.
    task automatic drain();
        while (items_taken != items_queued || drive_due_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic int clip16(input int v);
        if (v < S16_MIN)
        begin
            return S16_MIN;
        end
        if (v > S16_MAX)
        begin
            return S16_MAX;
        end
        return v;
    endfunction

    // Signed gain: mostly small so the loop does not just sit in the clamp.
    function automatic logic [DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return DATA_W'(S16_MIN);
            1:       return DATA_W'(S16_MAX);
            2, 3:    return DATA_W'($urandom);
            default: return DATA_W'(int'($urandom_range(0, 32)) - 16);
        endcase
    endfunction

    // Fresh register settings for one segment; pipeline must be empty.
    task automatic shuffle_regs();
        int lo;
        int hi;
        int span;
        write_reg(CFG_GAIN_P, pick_gain());
        write_reg(CFG_GAIN_I, pick_gain());
        case ($urandom_range(0, 5))
            0:       write_reg(CFG_GAIN_D, '0);
            1:       write_reg(CFG_GAIN_D, DATA_W'(8'hFF));
            2:       write_reg(CFG_GAIN_D, DATA_W'($urandom_range(0, 255)));
            default: write_reg(CFG_GAIN_D, DATA_W'($urandom_range(0, 15)));
        endcase
        case ($urandom_range(0, 7))
            0:
            begin
                lo = S16_MIN;
                hi = S16_MAX;
            end
            1:
            begin
                // crossed bounds: upper one wins
                lo = int'($urandom_range(0, 2000));
                hi = -int'($urandom_range(0, 2000));
            end
            2:
            begin
                lo = S16_MAX;
                hi = S16_MIN;
            end
            3:
            begin
                lo = int'($urandom_range(0, 400)) - 200;
                hi = lo;
            end
            4:
            begin
                lo = $signed(16'($urandom));
                hi = $signed(16'($urandom));
            end
            default:
            begin
                span = int'($urandom_range(16, 20000));
                lo = clip16(-span + int'($urandom_range(0, 64)) - 32);
                hi = clip16(span + int'($urandom_range(0, 64)) - 32);
            end
        endcase
        write_reg(CFG_OUT_MIN, DATA_W'(lo));
        write_reg(CFG_OUT_MAX, DATA_W'(hi));
        if ($urandom_range(0, 2) == 0)
        begin
            write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                      DATA_W'($urandom));
        end
    endtask

    // Mostly closed-loop traffic (held setpoint, measurement creeping toward
    // it), plus raw random beats and field extremes.
    task automatic queue_random(input int count);
        int kind;
        int step;
        int corner[5];
        corner = '{S16_MIN, -1, 0, 1, S16_MAX};
        for (int k = 0; k < count; k++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                if ($urandom_range(0, 24) == 0)
                begin
                    track_tgt = $signed(16'($urandom));
                end
                step = (track_tgt - track_meas) / 8 + int'($urandom_range(0, 128)) - 64;
                track_meas = clip16(track_meas + step);
                queue_sample(track_tgt, track_meas);
            end
            else if (kind < 85)
            begin
                queue_sample($signed(16'($urandom)), $signed(16'($urandom)));
            end
            else
            begin
                queue_sample(corner[$urandom_range(0, 4)], corner[$urandom_range(0, 4)]);
            end
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int segments);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int k = 0; k < segments; k++)
        begin
            drain();
            shuffle_regs();
            queue_random($urandom_range(60, 130));
        end
    endtask

    initial
    begin
        send_idle_pct = 35;
        recv_idle_pct = 61;
        wait (rst_n === 1'b1);

        // Gains only; bounds keep their reset values. The very first beat
        // must see a zero slope term even with a large measured value.
        write_reg(CFG_GAIN_P, DATA_W'(3));
        write_reg(CFG_GAIN_I, DATA_W'(-7));
        write_reg(CFG_GAIN_D, DATA_W'(200));
        queue_sample(100, S16_MIN);
        queue_sample(S16_MAX, S16_MIN);
        queue_sample(S16_MIN, S16_MAX);
        queue_sample(0, 0);
        queue_sample(-1, 1);
        queue_sample(S16_MAX, S16_MAX);
        queue_sample(S16_MIN, S16_MIN);
        queue_sample(1234, -4321);

        // Crossed bounds: upper bound wins for integrator and drive.
        drain();
        write_reg(CFG_OUT_MIN, DATA_W'(100));
        write_reg(CFG_OUT_MAX, DATA_W'(-100));
        queue_sample(500, 0);
        queue_sample(-500, 0);
        queue_sample(0, 0);

        // Most negative P and I gains, largest slope gain, full-scale steps, widest bounds.
        drain();
        write_reg(CFG_GAIN_P, DATA_W'(S16_MIN));
        write_reg(CFG_GAIN_I, DATA_W'(S16_MIN));
        write_reg(CFG_GAIN_D, DATA_W'(8'hFF));
        write_reg(CFG_OUT_MIN, DATA_W'(S16_MIN));
        write_reg(CFG_OUT_MAX, DATA_W'(S16_MAX));
        queue_sample(S16_MAX, S16_MIN);
        queue_sample(S16_MIN, S16_MAX);
        queue_sample(0, 100);
        queue_sample(0, -100);

        // Most positive gains against a narrow window.
        drain();
        write_reg(CFG_GAIN_P, DATA_W'(S16_MAX));
        write_reg(CFG_GAIN_I, DATA_W'(S16_MAX));
        write_reg(CFG_OUT_MIN, DATA_W'(-5));
        write_reg(CFG_OUT_MAX, DATA_W'(5));
        queue_sample(10, 3);
        queue_sample(-10, 3);
        queue_sample(S16_MAX, 0);
        queue_sample(0, S16_MAX);

        // Writes to unused indexes must change nothing.
        drain();
        write_reg(CFG_SPARE_FIRST, '1);
        write_reg(CFG_SPARE_LAST, '1);
        queue_sample(7, 7);

        // Zero-width window at zero, no slope gain.
        drain();
        write_reg(CFG_GAIN_D, '0);
        write_reg(CFG_OUT_MIN, '0);
        write_reg(CFG_OUT_MAX, '0);
        queue_sample(100, 200);

        // Random part: receiver-heavy idling, then sender-heavy, then none.
        run_phase(35, 61, 6);
        run_phase(61, 35, 6);
        run_phase(0, 0, 6);

        drain();
        repeat (DRAIN_SLACK) @(posedge clk);

        $display("Sent %0d input beats over %0d register writes in three idle mixes;",
                 items_taken, reg_writes);
        $display("checked %0d drive beats, %0d mismatches.", drives_checked, error_count);
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/pcc_pkg.sv
sv/pcc_front.sv
sv/pcc_mul.sv
sv/pcc_acc.sv
sv/pid_controller_clamped_core.sv
bench/pid_controller_clamped_core_tb.sv
